>>> hdl/rate_monotonic_tick_scheduler_top_assert.svh
// Assertion macros used by the rate-monotonic tick scheduler core (rmts_sched_core).
// The including scope must provide clk_i and rst_ni.
`ifndef RATE_MONOTONIC_TICK_SCHEDULER_TOP_ASSERT_SVH
`define RATE_MONOTONIC_TICK_SCHEDULER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RMTS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rmts: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define RMTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rmts: next-cycle check failed");

`endif

>>> hdl/rmts_pkg.sv
// Package for the rate-monotonic tick scheduler: widths, register indices
// and the structs passed between modules. No dependencies.
`timescale 1ns / 1ps

package rmts_pkg;

  localparam int unsigned SlotCap = 8;
  localparam int unsigned ValW    = 8;
  localparam int unsigned TickW   = 16;
  localparam int unsigned TaskIdW = 4;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 64;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TASK_COUNT   = 2'd0,
    CFG_EXEC_TABLE   = 2'd1,
    CFG_PERIOD_TABLE = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [TaskIdW-1:0]      task_count;
    logic [SlotCap*ValW-1:0] exec_table;
    logic [SlotCap*ValW-1:0] period_table;
  } cfg_t;

  typedef struct packed {
    logic [TaskIdW-1:0] running_task;
    logic               switched;
    logic [SlotCap-1:0] miss_mask;
    logic [TickW-1:0]   tick_time;
  } result_t;

endpackage

>>> hdl/rmts_cfg_regs.sv
// Configuration register file of the tick scheduler.
// Depends on rmts_pkg.
`timescale 1ns / 1ps

module rmts_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rmts_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [rmts_pkg::CfgDataW-1:0]  cfg_data_i,
  output rmts_pkg::cfg_t                 cfg_o
);

  rmts_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        rmts_pkg::CFG_TASK_COUNT:   cfg_d.task_count   = cfg_data_i[rmts_pkg::TaskIdW-1:0];
        rmts_pkg::CFG_EXEC_TABLE:   cfg_d.exec_table   = cfg_data_i;
        rmts_pkg::CFG_PERIOD_TABLE: cfg_d.period_table = cfg_data_i;
        default:                    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hdl/rmts_sched_core.sv
// Scheduler state (budgets, phases, tick counter, previous choice) and the
// combinational release, miss and selection logic. Depends on rmts_pkg.
`timescale 1ns / 1ps

module rmts_sched_core #(
  parameter int unsigned TASKS     = 8,
  parameter int unsigned TIME_BITS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              restart_i,
  input  rmts_pkg::cfg_t    cfg_i,
  output rmts_pkg::result_t res_o
);

  `include "rate_monotonic_tick_scheduler_top_assert.svh"

  localparam int unsigned NumSlots =
      (TASKS < rmts_pkg::SlotCap) ? TASKS : rmts_pkg::SlotCap;
  localparam int unsigned VW =
      (TIME_BITS < rmts_pkg::ValW) ? TIME_BITS : rmts_pkg::ValW;

  logic [VW-1:0] budget_q [NumSlots];
  logic [VW-1:0] budget_d [NumSlots];
  logic [VW-1:0] phase_q  [NumSlots];
  logic [VW-1:0] phase_d  [NumSlots];
  logic [rmts_pkg::TickW-1:0]   tick_q, tick_d, tick_now;
  logic [rmts_pkg::TaskIdW-1:0] prev_choice_q, prev_choice_d;
  logic                         prev_valid_q;

  logic [VW-1:0] per_s    [NumSlots];
  logic [VW-1:0] exec_s   [NumSlots];
  logic [VW-1:0] avail_s  [NumSlots];
  logic [NumSlots-1:0] en_s;
  logic [rmts_pkg::SlotCap-1:0] miss;
  logic [rmts_pkg::TaskIdW-1:0] choice;
  logic                         first;

  always_comb begin
    logic [VW:0]   best_per;
    logic [VW-1:0] budget_eff;
    logic [VW-1:0] phase_eff;
    logic [VW:0]   ph_inc;
    logic          release_now;

    first    = restart_i || !prev_valid_q;
    tick_now = restart_i ? '0 : tick_q;
    tick_d   = tick_now + rmts_pkg::TickW'(1);
    miss     = '0;
    choice   = '0;
    best_per = '1;

    // Release and deadline check for each slot.
    for (int i = 0; i < NumSlots; i++) begin
      per_s[i]    = cfg_i.period_table[rmts_pkg::ValW*i +: VW];
      exec_s[i]   = cfg_i.exec_table[rmts_pkg::ValW*i +: VW];
      en_s[i]     = (rmts_pkg::TaskIdW'(i) < cfg_i.task_count) && (per_s[i] != '0);
      budget_eff  = restart_i ? '0 : budget_q[i];
      phase_eff   = restart_i ? '0 : phase_q[i];
      release_now = en_s[i] && (phase_eff == '0);
      miss[i]     = release_now && (budget_eff != '0) && !first;
      if (!en_s[i]) begin
        avail_s[i] = '0;
      end else if (release_now) begin
        avail_s[i] = exec_s[i];
      end else begin
        avail_s[i] = budget_eff;
      end
      ph_inc = {1'b0, phase_eff} + (VW+1)'(1);
      if (!en_s[i] || (ph_inc >= {1'b0, per_s[i]})) begin
        phase_d[i] = '0;
      end else begin
        phase_d[i] = ph_inc[VW-1:0];
      end
    end

    // Shortest period wins; strict compare keeps the lowest index on ties.
    for (int i = 0; i < NumSlots; i++) begin
      if (en_s[i] && (avail_s[i] != '0) && ({1'b0, per_s[i]} < best_per)) begin
        best_per = {1'b0, per_s[i]};
        choice   = rmts_pkg::TaskIdW'(i + 1);
      end
    end

    for (int i = 0; i < NumSlots; i++) begin
      budget_d[i] = avail_s[i] - VW'(choice == rmts_pkg::TaskIdW'(i + 1));
    end

    prev_choice_d = choice;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumSlots; i++) begin
        budget_q[i] <= '0;
        phase_q[i]  <= '0;
      end
      tick_q        <= '0;
      prev_choice_q <= '0;
      prev_valid_q  <= 1'b0;
    end else if (step_i) begin
      for (int i = 0; i < NumSlots; i++) begin
        budget_q[i] <= budget_d[i];
        phase_q[i]  <= phase_d[i];
      end
      tick_q        <= tick_d;
      prev_choice_q <= prev_choice_d;
      prev_valid_q  <= 1'b1;
    end
  end

  assign res_o.running_task = choice;
  assign res_o.switched     = first || (choice != prev_choice_q);
  assign res_o.miss_mask    = miss;
  assign res_o.tick_time    = tick_now;

  `RMTS_ASSERT_NOW(a_choice_in_range, step_i, res_o.running_task <= rmts_pkg::TaskIdW'(NumSlots))
  `RMTS_ASSERT_NOW(a_miss_in_slots, step_i, (res_o.miss_mask >> NumSlots) == '0)
  `RMTS_ASSERT_NOW(a_first_switches, step_i && first, res_o.switched && (res_o.miss_mask == '0))
  `RMTS_ASSERT_NEXT(a_tick_advances, step_i, tick_q == ($past(tick_now) + rmts_pkg::TickW'(1)))
  `RMTS_ASSERT_NEXT(a_prev_tracks, step_i, prev_valid_q && (prev_choice_q == $past(choice)))

endmodule

>>> hdl/rmts_out_reg.sv
// Result register of the tick scheduler with its valid flag.
// Depends on rmts_pkg.
`timescale 1ns / 1ps

module rmts_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  rmts_pkg::result_t res_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output rmts_pkg::result_t res_o
);

  logic              valid_q, valid_d;
  rmts_pkg::result_t res_q;

  always_comb begin
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset; it is only seen while the valid flag is set.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

>>> hdl/rate_monotonic_tick_scheduler_top.sv
// Channel   Direction  Handshake                   Payload
// in        input      in_valid_i / in_ready_o      restart_i
// out       output     out_valid_o / out_ready_i    running_task_o, switched_o,
//                                                   miss_mask_o, tick_time_o
// cfg       input      cfg_we_i (no wait)           cfg_index_i, cfg_data_i
//
// One tick per cycle sustained unless out_ready_i stalls; a tick's result is valid
// after the input register and then the result register after the scheduling logic.
// The selection is a chain of period compares over at most eight slots.
// Reset clears budgets, phases, tick counter, previous choice and configuration.
// While the result register is full and out_ready_i is low, the input register
// holds its tick and in_ready_o falls once it is occupied.
// Depends on rmts_pkg, rmts_cfg_regs, rmts_sched_core and rmts_out_reg.
`timescale 1ns / 1ps

module rate_monotonic_tick_scheduler_top #(
  parameter int unsigned TASKS     = 8,
  parameter int unsigned TIME_BITS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rmts_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [rmts_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              restart_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [rmts_pkg::TaskIdW-1:0]      running_task_o,
  output logic                              switched_o,
  output logic [rmts_pkg::SlotCap-1:0]      miss_mask_o,
  output logic [rmts_pkg::TickW-1:0]        tick_time_o
);

  rmts_pkg::cfg_t    cfg;
  rmts_pkg::result_t core_res;
  rmts_pkg::result_t out_res;

  logic s1_valid_q, s1_valid_d;
  logic s1_restart_q;
  logic advance;
  logic in_xfer;

  // A tick leaves the input register when the result register is free or
  // is emptied in the same cycle.
  assign advance    = s1_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    if (in_xfer) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_restart_q <= restart_i;
    end
  end

  rmts_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  rmts_sched_core #(
    .TASKS     (TASKS),
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .restart_i (s1_restart_q),
    .cfg_i     (cfg),
    .res_o     (core_res)
  );

  rmts_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .res_i       (core_res),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .res_o       (out_res)
  );

  assign running_task_o = out_res.running_task;
  assign switched_o     = out_res.switched;
  assign miss_mask_o    = out_res.miss_mask;
  assign tick_time_o    = out_res.tick_time;

endmodule

>>> verif/tb.sv
// Self-checking testbench for rate_monotonic_tick_scheduler_top: a directed table of ticks, then
// random ticks and settings under varied back-pressure, checked against an in-bench scheduler.
// Depends on rmts_pkg and the scheduler RTL.
`timescale 1ns / 1ps

module tb;
  import rmts_pkg::*;

  logic                clk_i;
  logic                rst_ni       = 1'b0;
  logic                cfg_we_i     = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i  = CFG_TASK_COUNT;
  logic [CfgDataW-1:0] cfg_data_i   = '0;
  logic                in_valid_i   = 1'b0;
  logic                in_ready_o;
  logic                restart_i    = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i  = 1'b0;
  logic [TaskIdW-1:0]  running_task_o;
  logic                switched_o;
  logic [SlotCap-1:0]  miss_mask_o;
  logic [TickW-1:0]    tick_time_o;

  typedef struct packed {
    logic [1:0] setting;
    logic       restart;
    logic       typed;
    result_t    want;
  } drive_row_t;

  // Settings used by the directed table: reset values, a small overloaded set, and the extremes.
  cfg_t directed_cfg [3] = '{
    '{4'd0,  64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000},
    '{4'd3,  64'h0000_0000_0001_0203, 64'h0000_0000_0000_0204},
    '{4'd15, 64'h00FF_FFFF_FFFF_FFFF, 64'hFF80_4020_1008_FF01}
  };

  drive_row_t directed_rows [22] = '{
    '{2'd0, 1'b0, 1'b1, '{4'd0, 1'b1, 8'h00, 16'd0}},
    '{2'd0, 1'b0, 1'b1, '{4'd0, 1'b0, 8'h00, 16'd1}},
    '{2'd0, 1'b1, 1'b1, '{4'd0, 1'b1, 8'h00, 16'd0}},
    '{2'd0, 1'b0, 1'b1, '{4'd0, 1'b0, 8'h00, 16'd1}},
    '{2'd1, 1'b0, 1'b0, '0},
    '{2'd1, 1'b0, 1'b0, '0},
    '{2'd1, 1'b0, 1'b0, '0},
    '{2'd1, 1'b0, 1'b0, '0},
    '{2'd1, 1'b0, 1'b0, '0},
    '{2'd1, 1'b0, 1'b0, '0},
    '{2'd1, 1'b0, 1'b0, '0},
    '{2'd1, 1'b0, 1'b0, '0},
    '{2'd1, 1'b0, 1'b0, '0},
    '{2'd1, 1'b1, 1'b0, '0},
    '{2'd1, 1'b0, 1'b0, '0},
    '{2'd2, 1'b0, 1'b0, '0},
    '{2'd2, 1'b0, 1'b0, '0},
    '{2'd2, 1'b0, 1'b0, '0},
    '{2'd2, 1'b1, 1'b0, '0},
    '{2'd2, 1'b0, 1'b0, '0},
    '{2'd2, 1'b0, 1'b0, '0},
    '{2'd2, 1'b0, 1'b0, '0}
  };

  // Scheduler state as the bench sees it.
  cfg_t           sh_cfg = '0;
  logic [ValW-1:0] budget_left [SlotCap] = '{default: '0};
  logic [ValW-1:0] phase_pos   [SlotCap] = '{default: '0};
  logic [TickW-1:0]   tick_no     = '0;
  logic [TaskIdW-1:0] last_choice = '0;
  logic               last_valid  = 1'b0;

  result_t     predicted_slots [$];
  int unsigned mismatches    = 0;
  int unsigned send_gap_pct  = 0;
  int unsigned take_gap_pct  = 0;

  rate_monotonic_tick_scheduler_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .restart_i     (restart_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .running_task_o(running_task_o),
    .switched_o    (switched_o),
    .miss_mask_o   (miss_mask_o),
    .tick_time_o   (tick_time_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #15_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Advances the scheduler by one tick and returns the slot it reports.
  function automatic result_t schedule_tick(input logic restart);
    int unsigned      active;
    int unsigned      best;
    logic             first;
    logic [ValW-1:0]  per;
    logic [SlotCap-1:0] miss;
    logic [TaskIdW-1:0] choice;
    result_t          slot;
    active = (sh_cfg.task_count > SlotCap) ? SlotCap : sh_cfg.task_count;
    best   = 256;
    miss   = '0;
    choice = '0;
    if (restart) begin
      budget_left = '{default: '0};
      phase_pos   = '{default: '0};
      tick_no     = '0;
      last_choice = '0;
      last_valid  = 1'b0;
    end
    first = !last_valid;
    for (int i = 0; i < SlotCap; i++) begin
      per = sh_cfg.period_table[i*ValW +: ValW];
      if (i >= active || per == 0) begin
        budget_left[i] = '0;
        phase_pos[i]   = '0;
      end else if (phase_pos[i] == 0) begin
        if (budget_left[i] != 0 && !first) miss[i] = 1'b1;
        budget_left[i] = sh_cfg.exec_table[i*ValW +: ValW];
      end
    end
    for (int i = 0; i < active; i++) begin
      per = sh_cfg.period_table[i*ValW +: ValW];
      if (per != 0 && budget_left[i] != 0 && per < best) begin
        best   = per;
        choice = TaskIdW'(i + 1);
      end
    end
    if (choice != 0) budget_left[choice - 1] = budget_left[choice - 1] - 1'b1;
    for (int i = 0; i < active; i++) begin
      per = sh_cfg.period_table[i*ValW +: ValW];
      if (per != 0) begin
        if (phase_pos[i] + 1 >= per) phase_pos[i] = '0;
        else phase_pos[i] = phase_pos[i] + 1'b1;
      end
    end
    slot.running_task = choice;
    slot.switched     = first || (choice != last_choice);
    slot.miss_mask    = miss;
    slot.tick_time    = tick_no;
    tick_no     = tick_no + 1'b1;
    last_choice = choice;
    last_valid  = 1'b1;
    return slot;
  endfunction

  function automatic cfg_t random_setting();
    cfg_t s;
    case ($urandom_range(5))
      0:       s.task_count = 4'd0;
      1:       s.task_count = 4'd8;
      2:       s.task_count = 4'($urandom_range(9, 15));
      default: s.task_count = 4'($urandom_range(1, 8));
    endcase
    for (int i = 0; i < SlotCap; i++) begin
      case ($urandom_range(7))
        0:       s.exec_table[i*ValW +: ValW] = 8'h00;
        1:       s.exec_table[i*ValW +: ValW] = 8'hFF;
        2:       s.exec_table[i*ValW +: ValW] = 8'($urandom_range(255));
        default: s.exec_table[i*ValW +: ValW] = 8'($urandom_range(1, 3));
      endcase
      case ($urandom_range(7))
        0:       s.period_table[i*ValW +: ValW] = 8'h00;
        1:       s.period_table[i*ValW +: ValW] = 8'hFF;
        2:       s.period_table[i*ValW +: ValW] = 8'($urandom_range(255));
        default: s.period_table[i*ValW +: ValW] = 8'($urandom_range(1, 10));
      endcase
    end
    return s;
  endfunction

  // Holds the input side idle until every predicted slot has been transferred out.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (predicted_slots.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_setting(input cfg_t s);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_TASK_COUNT;
    cfg_data_i  <= CfgDataW'(s.task_count);
    @(posedge clk_i);
    cfg_index_i <= CFG_EXEC_TABLE;
    cfg_data_i  <= s.exec_table;
    @(posedge clk_i);
    cfg_index_i <= CFG_PERIOD_TABLE;
    cfg_data_i  <= s.period_table;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sh_cfg = s;
  endtask

  task automatic send_tick(input logic restart, input logic typed, input result_t want);
    result_t model_slot;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i  <= restart;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    model_slot = schedule_tick(restart);
    predicted_slots.push_back(typed ? want : model_slot);
  endtask

  always @(posedge clk_i) begin
    result_t want;
    out_ready_i <= ($urandom_range(99) >= take_gap_pct);
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (predicted_slots.size() == 0) begin
        $display("%0t: unexpected result transfer, running_task %0d", $time, running_task_o);
        mismatches++;
      end else begin
        want = predicted_slots.pop_front();
        if (running_task_o !== want.running_task) begin
          $display("%0t: running_task expected %0d, got %0d", $time, want.running_task,
                   running_task_o);
          mismatches++;
        end
        if (switched_o !== want.switched) begin
          $display("%0t: switched expected %0b, got %0b", $time, want.switched, switched_o);
          mismatches++;
        end
        if (miss_mask_o !== want.miss_mask) begin
          $display("%0t: miss_mask expected %h, got %h", $time, want.miss_mask, miss_mask_o);
          mismatches++;
        end
        if (tick_time_o !== want.tick_time) begin
          $display("%0t: tick_time expected %0d, got %0d", $time, want.tick_time, tick_time_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    logic [1:0] current_setting;
    current_setting = 2'd0;
    send_gap_pct = 29;
    take_gap_pct = 88;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].setting != current_setting) begin
        current_setting = directed_rows[r].setting;
        load_setting(directed_cfg[current_setting]);
      end
      send_tick(directed_rows[r].restart, directed_rows[r].typed, directed_rows[r].want);
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin send_gap_pct = 29; take_gap_pct = 88; end
        1:       begin send_gap_pct = 88; take_gap_pct = 29; end
        default: begin send_gap_pct = 0;  take_gap_pct = 0;  end
      endcase
      // No restart before a new setting, so periods often change mid-run.
      for (int blk = 0; blk < 6; blk++) begin
        load_setting(random_setting());
        repeat (105) send_tick($urandom_range(39) == 0, 1'b0, '0);
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/rmts_pkg.sv
hdl/rmts_cfg_regs.sv
hdl/rmts_sched_core.sv
hdl/rmts_out_reg.sv
hdl/rate_monotonic_tick_scheduler_top.sv
verif/tb.sv
